/* hdl/bdqs_pkg.sv */
// Package for the bounded deque with search.
// Request codes, result status codes, FSM states and default sizes.
// No dependencies.
`default_nettype none

package bdqs_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W   = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_FRONT = 4'd0,
    FN_ADD_BACK  = 4'd1,
    FN_RM_FRONT  = 4'd2,
    FN_RM_BACK   = 4'd3,
    FN_PEEK_FRNT = 4'd4,
    FN_PEEK_BACK = 4'd5,
    FN_RM_MATCH  = 4'd6,
    FN_FIND      = 4'd7,
    FN_DUMP      = 4'd8
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_END_RD,
    S_SCAN,
    S_SHIFT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

/* hdl/bounded_deque_with_search.sv */
// Bounded double-ended queue with search, top level.
// Entries live in one synchronous memory with a registered read port; uses bdqs_pkg.
// Find scans from the front to the first match; remove-match scans the same way and,
// on a hit, moves each entry behind the match one place toward the front.
// Dump returns one beat per entry from the front, last_o set on the final beat.
// One request at a time; the next is taken once the controller is back in idle, even
// while the last result waits in the output register. Reset: count, front pointer,
// controller and output valid cleared.
`default_nettype none

module bounded_deque_with_search #(
  parameter int DEPTH       = bdqs_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdqs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bdqs_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [bdqs_pkg::DATA_W-1:0]   value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bdqs_pkg::DATA_W-1:0]        data_o,
  output logic [bdqs_pkg::STATUS_W-1:0]      status_o,
  output logic [bdqs_pkg::OCC_W-1:0]         occupancy_o,
  output logic                               last_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int VW    = VALUE_WIDTH;
  localparam int DataW = bdqs_pkg::DATA_W;
  localparam int OccW  = bdqs_pkg::OCC_W;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(front) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return AW'(sum);
  endfunction

  bdqs_pkg::state_e  state_q, state_d;
  bdqs_pkg::func_e   func_q, func_d;
  logic [VW-1:0]     key_q, key_d;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     cmp_pos_q, cmp_pos_d;
  logic              cmp_v_q, cmp_v_d;
  logic [CW-1:0]     wr_pos_q, wr_pos_d;
  logic              sh_v_q, sh_v_d;
  logic [VW-1:0]     res_data_q, res_data_d;
  bdqs_pkg::status_e res_status_q, res_status_d;

  logic                         out_valid_q, out_valid_d;
  logic [DataW-1:0]             data_q, data_d;
  logic [bdqs_pkg::STATUS_W-1:0] status_q, status_d;
  logic [OccW-1:0]              occ_q, occ_d;
  logic                         last_q, last_d;

  logic [VW-1:0] entries_q [DEPTH];
  logic [VW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] mem_wdata;

  logic out_free;
  logic in_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == bdqs_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= entries_q[mem_raddr];
    end
  end

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    key_d        = key_q;
    front_d      = front_q;
    count_d      = count_q;
    pos_d        = pos_q;
    cmp_pos_d    = cmp_pos_q;
    cmp_v_d      = cmp_v_q;
    wr_pos_d     = wr_pos_q;
    sh_v_d       = sh_v_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    data_d       = data_q;
    status_d     = status_q;
    occ_d        = occ_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    mem_waddr    = front_q;
    mem_wdata    = key_q;
    mem_re       = 1'b0;
    mem_raddr    = front_q;

    case (state_q)
      bdqs_pkg::S_IDLE: begin
        if (in_acc) begin
          func_d  = bdqs_pkg::func_e'(func_i);
          key_d   = VW'(value_i);
          state_d = bdqs_pkg::S_EXEC;
        end
      end

      bdqs_pkg::S_EXEC: begin
        res_data_d   = '0;
        res_status_d = bdqs_pkg::STS_OK;
        state_d      = bdqs_pkg::S_RESP;
        case (func_q)
          bdqs_pkg::FN_ADD_FRONT, bdqs_pkg::FN_ADD_BACK: begin
            if (count_q == CW'(DEPTH)) begin
              res_status_d = bdqs_pkg::STS_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
              if (func_q == bdqs_pkg::FN_ADD_FRONT) begin
                front_d   = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
                mem_waddr = front_d;
              end else begin
                mem_waddr = slot(front_q, count_q);
              end
            end
          end
          bdqs_pkg::FN_RM_FRONT, bdqs_pkg::FN_RM_BACK,
          bdqs_pkg::FN_PEEK_FRNT, bdqs_pkg::FN_PEEK_BACK: begin
            if (count_q == '0) begin
              res_status_d = bdqs_pkg::STS_EMPTY;
            end else begin
              mem_re = 1'b1;
              if (func_q == bdqs_pkg::FN_RM_FRONT || func_q == bdqs_pkg::FN_PEEK_FRNT) begin
                mem_raddr = front_q;
              end else begin
                mem_raddr = slot(front_q, count_q - CW'(1));
              end
              state_d = bdqs_pkg::S_END_RD;
            end
          end
          bdqs_pkg::FN_RM_MATCH, bdqs_pkg::FN_FIND: begin
            if (count_q == '0) begin
              res_status_d = bdqs_pkg::STS_MISS;
            end else begin
              pos_d   = '0;
              cmp_v_d = 1'b0;
              state_d = bdqs_pkg::S_SCAN;
            end
          end
          bdqs_pkg::FN_DUMP: begin
            if (count_q == '0) begin
              res_status_d = bdqs_pkg::STS_EMPTY;
            end else begin
              pos_d   = '0;
              state_d = bdqs_pkg::S_DUMP_RD;
            end
          end
          default: begin
          end
        endcase
      end

      bdqs_pkg::S_END_RD: begin
        res_data_d = rdata_q;
        if (func_q == bdqs_pkg::FN_RM_FRONT) begin
          front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
          count_d = count_q - CW'(1);
        end else if (func_q == bdqs_pkg::FN_RM_BACK) begin
          count_d = count_q - CW'(1);
        end
        state_d = bdqs_pkg::S_RESP;
      end

      bdqs_pkg::S_SCAN: begin
        // read issue and compare are one entry apart
        if (pos_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot(front_q, pos_q);
          pos_d     = pos_q + CW'(1);
          cmp_pos_d = pos_q;
          cmp_v_d   = 1'b1;
        end else begin
          cmp_v_d = 1'b0;
        end
        if (cmp_v_q && rdata_q == key_q) begin
          res_data_d = rdata_q;
          cmp_v_d    = 1'b0;
          if (func_q == bdqs_pkg::FN_FIND) begin
            state_d = bdqs_pkg::S_RESP;
          end else begin
            pos_d    = cmp_pos_q + CW'(1);
            wr_pos_d = cmp_pos_q;
            sh_v_d   = 1'b0;
            state_d  = bdqs_pkg::S_SHIFT;
          end
        end else if (cmp_v_q && cmp_pos_q == count_q - CW'(1)) begin
          res_data_d   = '0;
          res_status_d = bdqs_pkg::STS_MISS;
          state_d      = bdqs_pkg::S_RESP;
        end
      end

      bdqs_pkg::S_SHIFT: begin
        // entry at pos moves to pos - 1, one per cycle
        if (sh_v_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot(front_q, wr_pos_q);
          mem_wdata = rdata_q;
          wr_pos_d  = wr_pos_q + CW'(1);
        end
        if (pos_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot(front_q, pos_q);
          pos_d     = pos_q + CW'(1);
          sh_v_d    = 1'b1;
        end else begin
          sh_v_d  = 1'b0;
          count_d = count_q - CW'(1);
          state_d = bdqs_pkg::S_RESP;
        end
      end

      bdqs_pkg::S_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = slot(front_q, pos_q);
        state_d   = bdqs_pkg::S_DUMP_OUT;
      end

      bdqs_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          data_d      = DataW'(rdata_q);
          status_d    = bdqs_pkg::STS_OK;
          occ_d       = OccW'(count_q);
          last_d      = (pos_q == count_q - CW'(1));
          pos_d       = pos_q + CW'(1);
          state_d     = last_d ? bdqs_pkg::S_IDLE : bdqs_pkg::S_DUMP_RD;
        end
      end

      bdqs_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          data_d      = DataW'(res_data_q);
          status_d    = res_status_q;
          occ_d       = OccW'(count_q);
          last_d      = 1'b1;
          state_d     = bdqs_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bdqs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdqs_pkg::S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      cmp_v_q     <= 1'b0;
      sh_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      cmp_v_q     <= cmp_v_d;
      sh_v_q      <= sh_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    pos_q        <= pos_d;
    cmp_pos_q    <= cmp_pos_d;
    wr_pos_q     <= wr_pos_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    data_q       <= data_d;
    status_q     <= status_d;
    occ_q        <= occ_d;
    last_q       <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* hdl/bdqs_chk.sv */
// Port-level checker for bounded_deque_with_search, bound to the top level.
// Uses bdqs_pkg for status codes.
`default_nettype none

module bdqs_chk #(
  parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [bdqs_pkg::STATUS_W-1:0] status_o,
  input wire logic [bdqs_pkg::OCC_W-1:0]    occupancy_o,
  input wire logic                          last_o
);

  localparam int OccW = bdqs_pkg::OCC_W;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before accept");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 31) || (occupancy_o <= OccW'(DEPTH)))
    else $error("occupancy above depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bdqs_pkg::STS_FULL |->
      occupancy_o == OccW'(DEPTH) && last_o)
    else $error("full status with queue not full");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bdqs_pkg::STS_EMPTY |-> occupancy_o == '0 && last_o)
    else $error("empty status with entries held");

endmodule

bind bounded_deque_with_search bdqs_chk #(
  .DEPTH(DEPTH)
) u_bdqs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .occupancy_o (occupancy_o),
  .last_o      (last_o)
);

`default_nettype wire
